// File: rtl/rsit_pkg.sv
// Shared types, constants and operation codes of the row start index table.
package rsit_pkg;

	// Table geometry.
	localparam int NY          = 511;
	localparam int DEPTH       = 2 * NY + 1;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int LAST_ROW_QA = 2 * NY - 2;
	localparam int SCAN_TOP    = 2 * NY - 1;

	// Field widths.
	localparam int KIND_W = 3;
	localparam int ROW_W  = 10;
	localparam int IDX_W  = 16;
	localparam int CNT_W  = 17;

	localparam int MAX_ENTRIES = 65536;

	// Operation codes carried in the kind field.
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HIT     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FINAL   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_QBEFORE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QAFTER  = 3'd4;

	// One table word: filled flag and the start position of the row.
	typedef struct packed {
		logic             filled;
		logic [IDX_W-1:0] start;
	} entry_t;

	// Access of the sequencer to the table memory.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Answer of a query handed to the output stage.
	typedef struct packed {
		logic             valid;
		logic [CNT_W-1:0] data;
	} res_t;

endpackage

// File: rtl/rsit_table_mem.sv
// Single-port-write, single-port-read table memory with registered read data.
module rsit_table_mem import rsit_pkg::*; (
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_q <= mem_q[req.raddr];
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/rsit_ctrl.sv
// Sequencer that walks the table with one shared index stepper for clear, finalize and queries.
module rsit_ctrl import rsit_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  logic [ROW_W-1:0]  row,
	input  logic [IDX_W-1:0]  hit_index,
	input  logic [CNT_W-1:0]  entry_count,
	output logic              ready,
	output mem_req_t          mem_req,
	input  entry_t            rd_data,
	output res_t              res,
	input  logic              res_ready
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EV   = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] idx_q;
	logic [KIND_W-1:0] op_q;
	logic              prev_valid_q;
	logic [ROW_W-1:0]  prev_row_q;
	logic [CNT_W-1:0]  ans_q;

	logic              row_in_table;
	logic              hit_new;
	logic [CNT_W-1:0]  default_end;
	logic              step_down;
	logic [ADDR_W-1:0] idx_next;
	logic [ADDR_W-1:0] limit;
	logic              at_limit;
	int                qb_start;

	assign ready        = (state_q == ST_IDLE);
	assign row_in_table = (int'(row) < DEPTH);
	assign hit_new      = row_in_table && (!prev_valid_q || (prev_row_q != row));
	assign default_end  = entry_count - CNT_W'(1);

	// Query before starts one row down, clamped to the top of the table.
	assign qb_start = (int'(row) - 1 > DEPTH - 1) ? DEPTH - 1 : int'(row) - 1;

	// Shared index stepper: one increment or decrement and one limit compare.
	assign step_down = (state_q == ST_EV) && (op_q == KIND_QBEFORE);
	assign idx_next  = step_down ? idx_q - ADDR_W'(1) : idx_q + ADDR_W'(1);

	always_comb begin
		limit = ADDR_W'(DEPTH - 1);
		if (state_q == ST_EV) begin
			case (op_q)
				KIND_QBEFORE: limit = '0;
				KIND_QAFTER:  limit = ADDR_W'(SCAN_TOP);
				default:      limit = ADDR_W'(DEPTH - 1);
			endcase
		end
	end

	assign at_limit = (idx_q == limit);

	// Table access: clearing pass, hit recording and finalize fill.
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q;
		mem_req.wdata = '0;
		mem_req.raddr = idx_q;
		unique case (state_q)
			ST_CLR: begin
				mem_req.we = 1'b1;
			end
			ST_IDLE: begin
				if (start && (kind == KIND_HIT) && hit_new) begin
					mem_req.we           = 1'b1;
					mem_req.waddr        = ADDR_W'(row);
					mem_req.wdata.filled = 1'b1;
					mem_req.wdata.start  = hit_index;
				end
			end
			ST_EV: begin
				if ((op_q == KIND_FINAL) && !rd_data.filled) begin
					mem_req.we           = 1'b1;
					mem_req.wdata.filled = 1'b1;
				end
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	assign res.valid = (state_q == ST_OUT);
	assign res.data  = ans_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			idx_q        <= '0;
			op_q         <= KIND_CLEAR;
			prev_valid_q <= 1'b0;
			prev_row_q   <= '0;
			ans_q        <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					idx_q <= idx_next;
					if (at_limit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						op_q <= kind;
						case (kind)
							KIND_CLEAR: begin
								prev_valid_q <= 1'b0;
								idx_q        <= '0;
								state_q      <= ST_CLR;
							end
							KIND_HIT: begin
								if (row_in_table) begin
									prev_valid_q <= 1'b1;
									prev_row_q   <= row;
								end
							end
							KIND_FINAL: begin
								if (entry_count != '0) begin
									idx_q   <= '0;
									state_q <= ST_RD;
								end
							end
							KIND_QBEFORE: begin
								if (row == '0) begin
									ans_q   <= '0;
									state_q <= ST_OUT;
								end else begin
									idx_q   <= ADDR_W'(qb_start);
									state_q <= ST_RD;
								end
							end
							KIND_QAFTER: begin
								if ((int'(row) > LAST_ROW_QA) || (int'(row) + 2 > SCAN_TOP)) begin
									ans_q   <= default_end;
									state_q <= ST_OUT;
								end else begin
									idx_q   <= ADDR_W'(int'(row) + 2);
									state_q <= ST_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					case (op_q) inside
						KIND_FINAL: begin
							if (rd_data.filled || at_limit) begin
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= idx_next;
								state_q <= ST_RD;
							end
						end
						KIND_QBEFORE, KIND_QAFTER: begin
							if (rd_data.filled) begin
								ans_q   <= {1'b0, rd_data.start};
								state_q <= ST_OUT;
							end else if (at_limit) begin
								ans_q   <= (op_q == KIND_QBEFORE) ? '0 : default_end;
								state_q <= ST_OUT;
							end else begin
								idx_q   <= idx_next;
								state_q <= ST_RD;
							end
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/row_start_index_table.sv
// Top level of the row start index table: configuration, output register and table.
//
// The table holds, per row, the position of the first hit of a row-sorted hit stream and
// answers "nearest filled row below" and "nearest filled row at least two above" requests.
// Hit requests do not occupy the sequencer and stream back to back. Clear, finalize and
// query requests walk the single table memory with one index stepper; finalize and queries
// pass each row visited through a read and an evaluate state, as the memory read data is
// registered. During clear and the pass after reset no request is accepted (entry_count
// writes are still taken); finalize visits the leading empty rows; a query scans until a
// filled row or the end of its range and then hands over its answer. Only queries return a
// result, held in an output register so the next request is accepted while the answer waits.
module row_start_index_table import rsit_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [KIND_W-1:0]       kind,
	input  logic [ROW_W-1:0]        row,
	input  logic [IDX_W-1:0]        hit_index,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [CNT_W-1:0] found_index,
	input  logic                    cfg_we,
	input  logic [CNT_W-1:0]        cfg_wdata
);

	logic             entry_count_q;
	logic [CNT_W-1:0] entry_cnt_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] found_q;
	logic             ready;
	logic             accept;
	logic             res_ready;
	mem_req_t         mem_req;
	entry_t           rd_data;
	res_t             res;

	assign accept   = in_valid && ready;
	assign in_stall = !ready;

	// Entry count register, saturated to the container capacity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q   <= '0;
			entry_count_q <= 1'b0;
		end else if (cfg_we) begin
			entry_cnt_q   <= (cfg_wdata > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : cfg_wdata;
			entry_count_q <= 1'b1;
		end
	end

	rsit_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.kind        (kind),
		.row         (row),
		.hit_index   (hit_index),
		.entry_count (entry_cnt_q),
		.ready       (ready),
		.mem_req     (mem_req),
		.rd_data     (rd_data),
		.res         (res),
		.res_ready   (res_ready)
	);

	rsit_table_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	// Output register: loads an answer whenever it is empty or being taken.
	assign res_ready = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			found_q <= res.data;
		end
	end

	assign out_valid   = out_valid_q;
	assign found_index = $signed(found_q);

	// A hit request never blocks the next request.
	a_hit_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_HIT)) |=> !in_stall)
		else $error("hit request left the block busy");

	// Clear and query requests always leave the input stalled in the cycle after they are accepted.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((kind == KIND_CLEAR) || (kind == KIND_QBEFORE) || (kind == KIND_QAFTER)))
		|=> in_stall)
		else $error("clear or query request did not start a scan");

	// The output register only fills from a pending answer of the sequencer.
	a_out_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(res.valid))
		else $error("output became valid without an answer");

	// An answer waiting in the sequencer keeps the input side stalled.
	a_res_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res_ready) |=> (res.valid && in_stall))
		else $error("pending answer was dropped");

	// Saturation keeps the entry count within the container capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q |-> (entry_cnt_q <= CNT_W'(MAX_ENTRIES)))
		else $error("entry count above capacity");

endmodule

// File: dv/row_start_index_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the row start index table, with its scoreboard and stimulus.

// Scoreboard: keeps its own copy of the row table and the queue of answers still to come.
class start_table_scoreboard;
	typedef logic [rsit_pkg::CNT_W-1:0] count_t;

	bit                                first_valid[rsit_pkg::DEPTH];
	logic [rsit_pkg::IDX_W-1:0]        first_pos[rsit_pkg::DEPTH];
	bit                                any_hit_seen;
	logic [rsit_pkg::ROW_W-1:0]        last_hit_row;
	logic [rsit_pkg::CNT_W-1:0]        hit_total;
	logic [rsit_pkg::CNT_W-1:0]        answers_due[$];
	int unsigned                       n_requests;
	int unsigned                       n_effective;
	int unsigned                       n_hits;
	int unsigned                       n_queries;
	int unsigned                       n_checked;
	int unsigned                       n_errors;

	function new();
		foreach (first_valid[i]) begin
			first_valid[i] = 1'b0;
			first_pos[i]   = '0;
		end
		any_hit_seen = 1'b0;
		last_hit_row = '0;
		hit_total    = '0;
		n_requests   = 0;
		n_effective  = 0;
		n_hits       = 0;
		n_queries    = 0;
		n_checked    = 0;
		n_errors     = 0;
	endfunction

	// A written total above the table capacity saturates.
	function void write_count(logic [rsit_pkg::CNT_W-1:0] value);
		if (value > rsit_pkg::MAX_ENTRIES)
			hit_total = count_t'(rsit_pkg::MAX_ENTRIES);
		else
			hit_total = value;
	endfunction

	function int pending();
		return answers_due.size();
	endfunction

	// Apply one accepted request to the table and queue its answer, if it has one.
	function void note_request(logic [rsit_pkg::KIND_W-1:0] op, logic [rsit_pkg::ROW_W-1:0] r,
			logic [rsit_pkg::IDX_W-1:0] pos);
		int                         i;
		int                         lowest;
		bit                         hit_found;
		logic [rsit_pkg::CNT_W-1:0] answer;

		n_requests++;
		case (op)
			rsit_pkg::KIND_CLEAR: begin
				foreach (first_valid[j])
					first_valid[j] = 1'b0;
				any_hit_seen = 1'b0;
				n_effective++;
			end
			rsit_pkg::KIND_HIT: begin
				// Hits outside the table leave everything, the last row included, alone.
				if (r < rsit_pkg::DEPTH) begin
					if (!any_hit_seen || last_hit_row != r) begin
						first_pos[r]   = pos;
						first_valid[r] = 1'b1;
					end
					last_hit_row = r;
					any_hit_seen = 1'b1;
					n_effective++;
					n_hits++;
				end
			end
			rsit_pkg::KIND_FINAL: begin
				// Leading empty rows start at position 0; nothing happens for an empty container.
				n_effective++;
				if (hit_total != 0) begin
					lowest = rsit_pkg::DEPTH;
					for (i = rsit_pkg::DEPTH - 1; i >= 0; i--)
						if (first_valid[i])
							lowest = i;
					for (i = 0; i < lowest; i++) begin
						first_pos[i]   = '0;
						first_valid[i] = 1'b1;
					end
				end
			end
			rsit_pkg::KIND_QBEFORE: begin
				// Nearest filled row strictly below; rows past the table start at the top row.
				answer    = '0;
				hit_found = 1'b0;
				if (r != 0) begin
					i = int'(r) - 1;
					if (i > rsit_pkg::DEPTH - 1)
						i = rsit_pkg::DEPTH - 1;
					for (; i >= 0; i--)
						if (!hit_found && first_valid[i]) begin
							answer    = {1'b0, first_pos[i]};
							hit_found = 1'b1;
						end
				end
				answers_due = {answers_due, answer};
				n_effective++;
				n_queries++;
			end
			rsit_pkg::KIND_QAFTER: begin
				// Nearest filled row two or more above, never the top row; else the end of the list.
				answer    = hit_total - 1'b1;
				hit_found = 1'b0;
				if (r <= rsit_pkg::LAST_ROW_QA)
					for (i = int'(r) + 2; i <= rsit_pkg::SCAN_TOP; i++)
						if (!hit_found && first_valid[i]) begin
							answer    = {1'b0, first_pos[i]};
							hit_found = 1'b1;
						end
				answers_due = {answers_due, answer};
				n_effective++;
				n_queries++;
			end
			default: begin
				// Spare operation codes are dropped without an answer.
			end
		endcase
	endfunction

	// Compare one delivered answer with the oldest one due.
	function void check_result(logic [rsit_pkg::CNT_W-1:0] got);
		logic [rsit_pkg::CNT_W-1:0] want;

		if (answers_due.size() == 0) begin
			n_errors++;
			if (n_errors <= 10)
				$display("%0t: unexpected answer found_index=0x%05h", $realtime, got);
			return;
		end
		want = answers_due.pop_front();
		n_checked++;
		if (got !== want) begin
			n_errors++;
			if (n_errors <= 10)
				$display("%0t: found_index mismatch: expected 0x%05h, got 0x%05h",
					$realtime, want, got);
		end
	endfunction
endclass

module row_start_index_table_tb;
	import rsit_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;
	localparam int                KIND_TOP         = (1 << KIND_W) - 1;
	localparam int                ROW_TOP          = (1 << ROW_W) - 1;
	localparam int                CNT_TOP          = (1 << CNT_W) - 1;
	localparam int                ITEMS            = 1600;
	// Longest a request can keep the block busy: a full query scan or a clear pass.
	localparam int                SETTLE_CYCLES    = 2200;
	localparam int                HOLD_CYCLES      = 3000;
	localparam int                HOLD_AT_ANSWER   = 150;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [KIND_W-1:0]       kind      = '0;
	logic [ROW_W-1:0]        row       = '0;
	logic [IDX_W-1:0]        hit_index = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [CNT_W-1:0] found_index;
	logic                    cfg_we    = 1'b0;
	logic [CNT_W-1:0]        cfg_wdata = '0;

	start_table_scoreboard sb = new();
	bit                    no_idle = 1'b0;
	int unsigned           n_cfg   = 0;

	row_start_index_table i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.row         (row),
		.hit_index   (hit_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found_index (found_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Offer one request, with random idle cycles ahead of it, and wait until it is taken.
	task automatic send_req(input logic [KIND_W-1:0] op, input logic [ROW_W-1:0] r,
			input logic [IDX_W-1:0] pos);
		while (!no_idle && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= op;
		row       <= r;
		hit_index <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(op, r, pos);
	endtask

	// Let the block drain and settle, then write the entry count.
	task automatic write_entry_count(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_count(value);
		n_cfg++;
	endtask

	// Query row, leaning on the table edges now and then.
	function automatic logic [ROW_W-1:0] pick_query_row();
		case ($urandom_range(11))
			0:       return '0;
			1:       return ROW_W'(1);
			2:       return ROW_W'(LAST_ROW_QA);
			3:       return ROW_W'(SCAN_TOP);
			4:       return ROW_W'(DEPTH - 1);
			5:       return ROW_W'(ROW_TOP);
			default: return ROW_W'($urandom_range(ROW_TOP));
		endcase
	endfunction

	// One round: mostly clear, sorted hits, finalize and queries; some broken rounds and noise.
	task automatic build_round();
		int unsigned      pick;
		int unsigned      n_hit_reqs;
		int unsigned      step_top;
		int unsigned      cur_row;
		logic [IDX_W-1:0] pos;

		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(10, 30))
				send_req(KIND_W'($urandom_range(KIND_TOP)), ROW_W'($urandom_range(ROW_TOP)),
					IDX_W'($urandom));
			return;
		end
		if (pick >= 15 || $urandom_range(1) == 0)
			send_req(KIND_CLEAR, ROW_W'($urandom), IDX_W'($urandom));
		n_hit_reqs = $urandom_range(4, 80);
		step_top   = (2 * DEPTH) / n_hit_reqs;
		cur_row    = ($urandom_range(3) == 0) ? 0 : $urandom_range(300);
		pos        = IDX_W'($urandom);
		repeat (n_hit_reqs) begin
			send_req(KIND_HIT, ROW_W'(cur_row), pos);
			pos = pos + IDX_W'($urandom_range(1, 4));
			// Broken rounds jump around, so rows come back out of order.
			if (pick < 12 && $urandom_range(9) == 0)
				cur_row = $urandom_range(ROW_TOP);
			else
				cur_row = cur_row + $urandom_range(step_top);
			if (cur_row > ROW_TOP)
				cur_row = ROW_TOP;
		end
		if (pick < 12 || pick >= 15)
			send_req(KIND_FINAL, ROW_W'($urandom), IDX_W'($urandom));
		repeat ($urandom_range(8, 30))
			send_req(($urandom_range(1) == 0) ? KIND_QBEFORE : KIND_QAFTER,
				pick_query_row(), IDX_W'($urandom));
	endtask

	// Answer side: random stalls, a stall-free stretch and one long hold-off.
	initial begin
		int unsigned hold_left;
		int unsigned n_answers;

		hold_left = 0;
		n_answers = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(found_index);
				n_answers++;
				if (n_answers == HOLD_AT_ANSWER)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !no_idle && $urandom_range(99) < 7;
			end
		end
	end

	// Main stimulus.
	initial begin
		logic [CNT_W-1:0] count_plan[7];
		int unsigned      n_round;

		count_plan = '{CNT_W'(1), CNT_W'(65535), CNT_W'(0), CNT_W'(65536), CNT_W'(2),
			CNT_W'(CNT_TOP), CNT_W'(100000)};
		n_round    = 0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed requests against an empty container.
		write_entry_count('0);
		send_req(KIND_SPARE_FIRST, ROW_W'(ROW_TOP), '1);
		send_req(KIND_SPARE_LAST, '0, '0);
		send_req(KIND_FINAL, '0, '0);
		send_req(KIND_QBEFORE, '0, '0);
		send_req(KIND_QBEFORE, ROW_W'(ROW_TOP), '0);
		send_req(KIND_QAFTER, '0, '0);
		send_req(KIND_QAFTER, ROW_W'(DEPTH - 1), '0);
		send_req(KIND_HIT, ROW_W'(ROW_TOP), 16'h0001);
		send_req(KIND_HIT, '0, '1);
		send_req(KIND_HIT, '0, 16'h0005);
		send_req(KIND_HIT, ROW_W'(1), '0);
		send_req(KIND_HIT, ROW_W'(DEPTH - 1), 16'h1234);
		send_req(KIND_HIT, ROW_W'(SCAN_TOP), 16'hAAAA);
		send_req(KIND_QAFTER, ROW_W'(LAST_ROW_QA), '0);
		send_req(KIND_QAFTER, ROW_W'(LAST_ROW_QA - 1), '0);
		send_req(KIND_QBEFORE, ROW_W'(ROW_TOP), '0);
		send_req(KIND_QBEFORE, ROW_W'(1), '0);

		// Directed finalize cases with a saturated entry count.
		write_entry_count(CNT_W'(CNT_TOP));
		send_req(KIND_CLEAR, '0, '0);
		send_req(KIND_HIT, ROW_W'(5), 16'h5555);
		send_req(KIND_FINAL, '0, '0);
		send_req(KIND_QBEFORE, ROW_W'(3), '0);
		send_req(KIND_QAFTER, ROW_W'(LAST_ROW_QA), '0);
		send_req(KIND_CLEAR, '0, '0);
		send_req(KIND_HIT, ROW_W'(1), 16'h0003);
		send_req(KIND_FINAL, '0, '0);
		send_req(KIND_QBEFORE, ROW_W'(1), '0);
		send_req(KIND_QAFTER, '0, '0);

		// Random rounds, with a new entry count every few rounds.
		while (sb.n_effective < ITEMS) begin
			if (n_round % 4 == 0)
				write_entry_count((n_round / 4 < 7) ? count_plan[n_round / 4] :
					CNT_W'($urandom_range(CNT_TOP)));
			no_idle = sb.n_effective >= 500 && sb.n_effective < 800;
			build_round();
			n_round++;
		end
		no_idle = 1'b0;

		// Drain, then give the block time to show any stray answer.
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);

		$display("Run covered %0d requests: %0d hits, %0d queries, in %0d rounds.",
			sb.n_requests, sb.n_hits, sb.n_queries, n_round);
		$display("Checked %0d answers under %0d entry count settings; %0d mismatches.",
			sb.n_checked, n_cfg, sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("** row_start_index_table: PASSED **");
		end else begin
			$display("** row_start_index_table: FAILED **");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#150_000_000;
		$display("Timeout with %0d answers still due.", sb.pending());
		$display("** row_start_index_table: FAILED **");
		$finish;
	end

endmodule
